[rtl/scfr_pkg.sv]
// Shared types, constants and CRC function for the sync-framed velocity receiver.
package scfr_pkg;

   localparam int FRAME_BYTES = 15;
   localparam logic [3:0] PAYLOAD_LEN = 4'(FRAME_BYTES - 3);

   localparam logic [7:0] CRC_POLY = 8'h07;
   localparam logic [7:0] CRC_TOP = 8'h80;

   localparam logic [7:0] SYNC_FIRST_RESET = 8'd165;
   localparam logic [7:0] SYNC_SECOND_RESET = 8'd90;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
   localparam logic [15:0] AGE_MAX = 16'hFFFF;

   localparam logic [1:0] CSR_SYNC_FIRST = 2'd0;
   localparam logic [1:0] CSR_SYNC_SECOND = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT = 2'd2;

   typedef struct packed {
      logic cmd;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic frame_done;
      logic crc_error;
      logic cmd_valid;
      logic [31:0] vx_bits;
      logic [31:0] vy_bits;
      logic [31:0] wz_bits;
   } rsp_type;

   typedef enum logic {
      ITEM_BYTE = 1'b0,
      ITEM_TICK = 1'b1
   } item_kind_type;

   typedef struct packed {
      item_kind_type kind;
      logic [7:0] data;
   } item_type;

   typedef struct packed {
      logic valid;
      item_type item;
   } queue_head_type;

   typedef struct packed {
      logic [7:0] sync_first;
      logic [7:0] sync_second;
      logic [15:0] timeout_ms;
   } cfg_type;

   typedef enum logic [1:0] {
      PHASE_SYNC1 = 2'd0,
      PHASE_SYNC2 = 2'd1,
      PHASE_BODY = 2'd2
   } phase_type;

   function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] v;
      v = acc ^ b;
      for (int k = 0; k < 8; k++) begin
         if ((v & CRC_TOP) != 8'd0) begin
            v = (v << 1) ^ CRC_POLY;
         end else begin
            v = v << 1;
         end
      end
      return v;
   endfunction

endpackage

[rtl/scfr_front.sv]
// Input side: accepts beats, classifies them and holds them in a two-entry queue.
module scfr_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  scfr_pkg::req_type req_data,
   input  logic pop,
   output scfr_pkg::queue_head_type head
);
   import scfr_pkg::*;

   item_type queue_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic push;
   item_type new_item;

   assign req_stall = (count_ff == 2'd2);
   assign push = req_valid && !req_stall;

   always_comb begin
      new_item.kind = req_data.cmd ? ITEM_TICK : ITEM_BYTE;
      new_item.data = req_data.rx_byte;
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.item = queue_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

[rtl/scfr_back.sv]
// Execution side: framing state machine, CRC, held command, age counter and result register.
module scfr_back (
   input  logic clock,
   input  logic reset,
   input  scfr_pkg::cfg_type cfg,
   input  scfr_pkg::queue_head_type head,
   output logic pop,
   output logic rsp_valid,
   input  logic rsp_stall,
   output scfr_pkg::rsp_type rsp_data
);
   import scfr_pkg::*;

   phase_type phase_ff, phase_in;
   logic [3:0] byte_count_ff, byte_count_in;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] payload_shift_ff [12];
   logic shift_en;
   logic [31:0] held_ff [3];
   logic [31:0] held_in [3];
   logic fresh_ff, fresh_in;
   logic [15:0] age_ff, age_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic fire;
   logic done, bad;
   logic [7:0] b;

   assign fire = head.valid && (!rsp_valid_ff || !rsp_stall);
   assign pop = fire;
   assign b = head.item.data;

   always_comb begin
      phase_in = phase_ff;
      byte_count_in = byte_count_ff;
      crc_in = crc_ff;
      shift_en = 1'b0;
      held_in = held_ff;
      fresh_in = fresh_ff;
      age_in = age_ff;
      done = 1'b0;
      bad = 1'b0;
      if (head.item.kind == ITEM_TICK) begin
         if (age_ff != AGE_MAX) begin
            age_in = age_ff + 16'd1;
         end
         if (fresh_ff && (age_in > cfg.timeout_ms)) begin
            fresh_in = 1'b0;
         end
      end else begin
         case (phase_ff)
            PHASE_SYNC2: begin
               if (b == cfg.sync_second) begin
                  phase_in = PHASE_BODY;
                  byte_count_in = 4'd0;
                  crc_in = crc8_step(crc8_step(8'd0, cfg.sync_first), cfg.sync_second);
               end else if (b != cfg.sync_first) begin
                  phase_in = PHASE_SYNC1;
               end
            end
            PHASE_BODY: begin
               if (byte_count_ff < PAYLOAD_LEN) begin
                  shift_en = 1'b1;
                  crc_in = crc8_step(crc_ff, b);
                  byte_count_in = byte_count_ff + 4'd1;
               end else begin
                  if (b == crc_ff) begin
                     for (int w = 0; w < 3; w++) begin
                        held_in[w] = {payload_shift_ff[4*w+3], payload_shift_ff[4*w+2],
                                      payload_shift_ff[4*w+1], payload_shift_ff[4*w]};
                     end
                     fresh_in = 1'b1;
                     age_in = 16'd0;
                     done = 1'b1;
                  end else begin
                     bad = 1'b1;
                  end
                  phase_in = PHASE_SYNC1;
                  byte_count_in = 4'd0;
               end
            end
            default: begin
               phase_in = (b == cfg.sync_first) ? PHASE_SYNC2 : PHASE_SYNC1;
            end
         endcase
      end
   end

   always_comb begin
      rsp_data_in.frame_done = done;
      rsp_data_in.crc_error = bad;
      rsp_data_in.cmd_valid = fresh_in;
      rsp_data_in.vx_bits = held_in[0];
      rsp_data_in.vy_bits = held_in[1];
      rsp_data_in.wz_bits = held_in[2];
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_SYNC1;
         byte_count_ff <= 4'd0;
         crc_ff <= 8'd0;
         for (int w = 0; w < 3; w++) begin
            held_ff[w] <= 32'd0;
         end
         fresh_ff <= 1'b0;
         age_ff <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            phase_ff <= phase_in;
            byte_count_ff <= byte_count_in;
            crc_ff <= crc_in;
            held_ff <= held_in;
            fresh_ff <= fresh_in;
            age_ff <= age_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && shift_en) begin
         for (int i = 0; i < 11; i++) begin
            payload_shift_ff[i] <= payload_shift_ff[i+1];
         end
         payload_shift_ff[11] <= b;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

[rtl/sync_crc8_velocity_frame_receiver_core.sv]
// Top level of the sync-framed velocity command receiver with CRC-8 check and timeout.
// Takes one beat per clock unless req_stall is high: a received byte or a one-millisecond
// tick. A beat is classified and queued in a two-entry queue on the request side, and the
// frame logic takes one queued beat per cycle while the result side does not stall, so the
// sustained rate is one beat per cycle; a result is held in the result register after its
// beat leaves the queue. The per-byte CRC-8 update (polynomial 0x07) is combinational in
// the frame logic and sets its path. Every beat gives exactly one result; configuration
// writes are always ready and must only be issued while the block is idle.
module sync_crc8_velocity_frame_receiver_core (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  scfr_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output scfr_pkg::rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [15:0] csr_wdata
);
   import scfr_pkg::*;

   cfg_type cfg_ff, cfg_in;
   queue_head_type head;
   logic pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SYNC_FIRST: cfg_in.sync_first = csr_wdata[7:0];
            CSR_SYNC_SECOND: cfg_in.sync_second = csr_wdata[7:0];
            CSR_TIMEOUT: cfg_in.timeout_ms = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first <= SYNC_FIRST_RESET;
         cfg_ff.sync_second <= SYNC_SECOND_RESET;
         cfg_ff.timeout_ms <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   scfr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .pop       (pop),
      .head      (head)
   );

   scfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[bench/tb_sync_crc8_velocity_frame_receiver_core.sv]
// Testbench for the sync-framed CRC-8 velocity receiver: directed table, random frames, checker.
module tb_sync_crc8_velocity_frame_receiver_core;
   timeunit 1ns;
   timeprecision 1ps;

   import scfr_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HIST_DEPTH = FRAME_BYTES - 1;

   typedef enum logic [1:0] {
      ROW_BYTE,
      ROW_TICK,
      ROW_CRC
   } row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [7:0] val;
      logic pinned;
      rsp_type want;
   } row_type;

   typedef struct {
      logic pinned;
      rsp_type want;
   } pinned_status_type;

   localparam rsp_type NO_STATUS = '0;
   localparam rsp_type CRC_FAIL_STATUS = '{frame_done: 1'b0, crc_error: 1'b1, cmd_valid: 1'b0,
                                           vx_bits: 32'h0, vy_bits: 32'h0, wz_bits: 32'h0};

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = CSR_SYNC_FIRST;
   logic [15:0] csr_wdata = '0;

   sync_crc8_velocity_frame_receiver_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // deframer prediction state
   logic [7:0] sync_a = SYNC_FIRST_RESET;
   logic [7:0] sync_b = SYNC_SECOND_RESET;
   logic [15:0] expiry_limit = TIMEOUT_RESET;
   phase_type hunt = PHASE_SYNC1;
   logic [3:0] taken = '0;
   logic [7:0] crc_acc = '0;
   logic [7:0] body [FRAME_BYTES - 3];
   logic [31:0] held [3] = '{32'h0, 32'h0, 32'h0};
   logic fresh = 1'b0;
   logic [15:0] age = '0;

   rsp_type status_due [$];
   pinned_status_type pinned_q [$];
   logic [7:0] byte_hist [$];

   int beats_sent = 0;
   int mismatches = 0;
   int good_frames = 0;
   int crc_errors = 0;
   int expiries = 0;
   int settings_used = 1;
   int idle_cycles = 0;
   int stall_run = 0;
   bit hush = 1'b0;

   row_type hunt_rows [22] = '{
      '{ROW_TICK, 8'h00, 1'b1, NO_STATUS},
      '{ROW_BYTE, 8'h00, 1'b1, NO_STATUS},
      '{ROW_BYTE, 8'hFF, 1'b1, NO_STATUS},
      '{ROW_BYTE, SYNC_FIRST_RESET, 1'b1, NO_STATUS},
      '{ROW_BYTE, SYNC_FIRST_RESET, 1'b1, NO_STATUS},
      '{ROW_BYTE, SYNC_SECOND_RESET, 1'b1, NO_STATUS},
      '{ROW_BYTE, 8'h00, 1'b0, NO_STATUS},
      '{ROW_BYTE, 8'hFF, 1'b0, NO_STATUS},
      '{ROW_BYTE, 8'h80, 1'b0, NO_STATUS},
      '{ROW_BYTE, 8'h7F, 1'b0, NO_STATUS},
      '{ROW_BYTE, 8'h01, 1'b0, NO_STATUS},
      '{ROW_BYTE, 8'hFE, 1'b0, NO_STATUS},
      '{ROW_TICK, 8'hFF, 1'b0, NO_STATUS},
      '{ROW_BYTE, 8'h55, 1'b0, NO_STATUS},
      '{ROW_BYTE, 8'hAA, 1'b0, NO_STATUS},
      '{ROW_BYTE, 8'h0F, 1'b0, NO_STATUS},
      '{ROW_BYTE, 8'hF0, 1'b0, NO_STATUS},
      '{ROW_BYTE, 8'hC3, 1'b0, NO_STATUS},
      '{ROW_BYTE, 8'h3C, 1'b0, NO_STATUS},
      '{ROW_CRC, 8'hFF, 1'b1, CRC_FAIL_STATUS},
      '{ROW_BYTE, SYNC_SECOND_RESET, 1'b1, NO_STATUS},
      '{ROW_TICK, 8'h5A, 1'b1, NO_STATUS}
   };

   cfg_type sweep [6] = '{
      '{sync_first: 8'hA5, sync_second: 8'h5A, timeout_ms: 16'd1000},
      '{sync_first: 8'h00, sync_second: 8'hFF, timeout_ms: 16'd1},
      '{sync_first: 8'hFF, sync_second: 8'h00, timeout_ms: 16'd65534},
      '{sync_first: 8'h7E, sync_second: 8'h7E, timeout_ms: 16'd3},
      '{sync_first: 8'h3C, sync_second: 8'hC3, timeout_ms: 16'd20},
      '{sync_first: 8'hA5, sync_second: 8'h5A, timeout_ms: 16'd2}
   };

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [7:0] crc07(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] r;
      r = acc ^ b;
      repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
      return r;
   endfunction

   function automatic logic [7:0] hist_crc();
      logic [7:0] acc;
      acc = 8'h00;
      foreach (byte_hist[i]) acc = crc07(acc, byte_hist[i]);
      return acc;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic bit status_differs(input rsp_type want, input rsp_type got);
      return (want.frame_done !== got.frame_done) || (want.crc_error !== got.crc_error)
         || (want.cmd_valid !== got.cmd_valid) || (want.vx_bits !== got.vx_bits)
         || (want.vy_bits !== got.vy_bits) || (want.wz_bits !== got.wz_bits);
   endfunction

   task automatic log_status_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t %s: want done=%b err=%b valid=%b vx=%h vy=%h wz=%h",
                  $realtime, what, want.frame_done, want.crc_error, want.cmd_valid,
                  want.vx_bits, want.vy_bits, want.wz_bits);
         $display("   got done=%b err=%b valid=%b vx=%h vy=%h wz=%h",
                  got.frame_done, got.crc_error, got.cmd_valid,
                  got.vx_bits, got.vy_bits, got.wz_bits);
      end
   endtask

   task automatic advance_deframer(input req_type beat, output rsp_type status);
      logic [7:0] b;
      b = beat.rx_byte;
      status = '0;
      if (beat.cmd == ITEM_TICK) begin
         if (age != AGE_MAX) age = age + 16'd1;
         if (fresh && age > expiry_limit) fresh = 1'b0;
      end else begin
         case (hunt)
            PHASE_SYNC2: begin
               if (b == sync_b) begin
                  hunt = PHASE_BODY;
                  taken = '0;
                  crc_acc = crc07(crc07(8'h00, sync_a), sync_b);
               end else if (b != sync_a) begin
                  hunt = PHASE_SYNC1;
               end
            end
            PHASE_BODY: begin
               if (taken < PAYLOAD_LEN) begin
                  body[taken] = b;
                  crc_acc = crc07(crc_acc, b);
                  taken = taken + 4'd1;
               end else begin
                  if (b == crc_acc) begin
                     held[0] = {body[3], body[2], body[1], body[0]};
                     held[1] = {body[7], body[6], body[5], body[4]};
                     held[2] = {body[11], body[10], body[9], body[8]};
                     fresh = 1'b1;
                     age = '0;
                     status.frame_done = 1'b1;
                  end else begin
                     status.crc_error = 1'b1;
                  end
                  hunt = PHASE_SYNC1;
                  taken = '0;
               end
            end
            default: begin
               hunt = (b == sync_a) ? PHASE_SYNC2 : PHASE_SYNC1;
            end
         endcase
      end
      status.cmd_valid = fresh;
      status.vx_bits = held[0];
      status.vy_bits = held[1];
      status.wz_bits = held[2];
   endtask

   always @(posedge clock) begin : scoreboard
      rsp_type want;
      rsp_type predicted;
      pinned_status_type pin;
      logic was_fresh;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SYNC_FIRST: sync_a = csr_wdata[7:0];
               CSR_SYNC_SECOND: sync_b = csr_wdata[7:0];
               CSR_TIMEOUT: expiry_limit = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (status_due.size() == 0) begin
               log_status_mismatch("result with nothing pending", NO_STATUS, rsp_data);
            end else begin
               want = status_due.pop_front();
               if (status_differs(want, rsp_data))
                  log_status_mismatch("status mismatch", want, rsp_data);
            end
         end
         if (req_valid && !req_stall) begin
            was_fresh = fresh;
            advance_deframer(req_data, predicted);
            if (was_fresh && !fresh) expiries++;
            if (predicted.frame_done) good_frames++;
            if (predicted.crc_error) crc_errors++;
            pin.pinned = 1'b0;
            pin.want = predicted;
            if (pinned_q.size() != 0) pin = pinned_q.pop_front();
            status_due.push_back(pin.pinned ? pin.want : predicted);
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", idle_cycles);
            $display("tb_sync_crc8_velocity_frame_receiver_core failed");
            $finish;
         end
      end
   end

   always @(posedge clock) begin : sink_pacing
      if (stall_run > 0) begin
         stall_run--;
      end else if (!rsp_stall && !hush) begin
         rsp_stall <= 1'b1;
         stall_run = pick_gap();
      end else begin
         rsp_stall <= 1'b0;
         stall_run = $urandom_range(0, 12);
      end
   end

   task automatic send_beat(input item_kind_type kind, input logic [7:0] value,
                            input logic pinned, input rsp_type want);
      int gap;
      pinned_status_type pin;
      gap = hush ? 0 : pick_gap();
      pin.pinned = pinned;
      pin.want = want;
      pinned_q.push_back(pin);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{cmd: kind, rx_byte: value};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
      if (kind == ITEM_BYTE) begin
         byte_hist.push_back(value);
         if (byte_hist.size() > HIST_DEPTH) void'(byte_hist.pop_front());
      end
   endtask

   task automatic send_tick();
      send_beat(ITEM_TICK, 8'($urandom), 1'b0, NO_STATUS);
   endtask

   task automatic send_frame(input logic [7:0] flip);
      int fill;
      fill = $urandom_range(0, 9);
      send_beat(ITEM_BYTE, sync_a, 1'b0, NO_STATUS);
      send_beat(ITEM_BYTE, sync_b, 1'b0, NO_STATUS);
      repeat (int'(PAYLOAD_LEN)) begin
         if ($urandom_range(0, 9) == 0) send_tick();
         send_beat(ITEM_BYTE, (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom),
                   1'b0, NO_STATUS);
      end
      send_beat(ITEM_BYTE, hist_crc() ^ flip, 1'b0, NO_STATUS);
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (status_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input cfg_type c);
      drain_block();
      write_reg(CSR_SYNC_FIRST, {8'($urandom), c.sync_first});
      write_reg(CSR_SYNC_SECOND, {8'($urandom), c.sync_second});
      write_reg(CSR_TIMEOUT, c.timeout_ms);
      settings_used++;
   endtask

   task automatic run_mix(input int budget);
      int stop_at;
      int r;
      int k;
      stop_at = beats_sent + budget;
      while (beats_sent < stop_at) begin
         if ($urandom_range(0, 29) == 0) hush = !hush;
         if ($urandom_range(0, 149) == 0) drain_block();
         r = $urandom_range(0, 99);
         if (r < 55) begin
            send_frame(($urandom_range(0, 6) == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
         end else if (r < 75) begin
            if (expiry_limit <= 64 && $urandom_range(0, 2) == 0)
               k = $urandom_range(1, int'(expiry_limit) + 3);
            else
               k = $urandom_range(1, 4);
            repeat (k) send_tick();
         end else if (r < 93) begin
            repeat ($urandom_range(1, 4))
               send_beat(ITEM_BYTE, ($urandom_range(0, 3) == 0) ? sync_a : 8'($urandom),
                         1'b0, NO_STATUS);
         end else begin
            send_beat(ITEM_BYTE, sync_a, 1'b0, NO_STATUS);
            send_beat(ITEM_BYTE, sync_b, 1'b0, NO_STATUS);
            repeat ($urandom_range(0, 11)) send_beat(ITEM_BYTE, 8'($urandom), 1'b0, NO_STATUS);
         end
      end
      hush = 1'b0;
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (hunt_rows[i]) begin
         case (hunt_rows[i].kind)
            ROW_TICK: send_beat(ITEM_TICK, hunt_rows[i].val, hunt_rows[i].pinned,
                                hunt_rows[i].want);
            ROW_BYTE: send_beat(ITEM_BYTE, hunt_rows[i].val, hunt_rows[i].pinned,
                                hunt_rows[i].want);
            default: send_beat(ITEM_BYTE, hist_crc() ^ hunt_rows[i].val, hunt_rows[i].pinned,
                               hunt_rows[i].want);
         endcase
      end
      run_mix(150);

      foreach (sweep[i]) begin
         apply_setting(sweep[i]);
         run_mix(175);
      end

      apply_setting('{sync_first: 8'hA5, sync_second: 8'h5A, timeout_ms: 16'd0});
      send_frame(8'h00);
      repeat (2) send_tick();

      // hold the command with timeouts disabled
      apply_setting('{sync_first: 8'h81, sync_second: 8'h18, timeout_ms: 16'hFFFF});
      hush = 1'b1;
      send_frame(8'h00);
      repeat (40) send_tick();
      hush = 1'b0;
      drain_block();
      write_reg(CSR_TIMEOUT, 16'hFFFE);
      repeat (2) send_tick();

      drain_block();
      $display("sent %0d beats under %0d register settings", beats_sent, settings_used);
      $display("saw %0d good frames, %0d CRC errors, %0d command expiries",
               good_frames, crc_errors, expiries);
      if (mismatches == 0 && status_due.size() == 0) begin
         $display("tb_sync_crc8_velocity_frame_receiver_core passed");
      end else begin
         $display("%0d mismatches, %0d results outstanding", mismatches, status_due.size());
         $display("tb_sync_crc8_velocity_frame_receiver_core failed");
      end
      $finish;
   end

endmodule
